// ===== sv/utxo_pkg.sv =====
// Shared constants, codes and beat types of the spend engine.
package utxo_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W = 16;
    localparam int AMT_W = 40;
    localparam int ID_W  = 6;
    localparam int SUM_W = AMT_W + CNT_W;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    localparam logic [1:0] ACT_CREATE   = 2'd0;
    localparam logic [1:0] ACT_VALIDATE = 2'd1;
    localparam logic [1:0] ACT_CHECK    = 2'd2;
    localparam logic [1:0] ACT_SPEND    = 2'd3;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] owner_key;
        logic [AMT_W-1:0] amount;
        logic [ID_W-1:0]  entry_id;
    } req_beat_t;

    typedef struct packed {
        logic            status;
        logic            answer;
        logic [ID_W-1:0] result_id;
        logic            last;
    } rsp_beat_t;

    typedef struct packed {
        logic [KEY_W-1:0] owner;
        logic [AMT_W-1:0] amount;
        logic             spent;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_LOOKUP,
        ST_WALK,
        ST_SETTLE,
        ST_FINAL
    } state_t;

endpackage

// ===== sv/utxo_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
module utxo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/utxo_table_spend_engine.sv =====
// Spend engine over an append-only table of owner entries held in one RAM.
//
//  channel | payload    | valid     | stall     | beats per item
//  --------+------------+-----------+-----------+--------------------------
//  request | req_beat_t | req_valid | req_stall | 1
//  result  | rsp_beat_t | rsp_valid | rsp_stall | 1, or marked entries + 1
//
// Create, validate and check are accepted in ST_IDLE and answered from ST_CREATE
// or ST_LOOKUP. A spend walks the table in ST_WALK, reading one table entry a
// cycle from the RAM port while no marked entry waits on rsp_stall, and settles
// the outcome in ST_SETTLE and ST_FINAL.
// Reset clears the control state and the entry count; the RAM is not cleared,
// since only entries below the count are ever used.
module utxo_table_spend_engine
    import utxo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] collected_reg, collected_next;
    logic             short_reg, short_next;
    logic [AMT_W-1:0] change_reg, change_next;
    logic [1:0]       act_reg, act_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [AMT_W-1:0] amt_reg, amt_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_beat_t        rsp_reg, rsp_next;

    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    entry_t           ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [$bits(entry_t)-1:0] ram_rd_bits;
    entry_t           rd_entry;

    logic      slot_free;
    logic      walk_done;
    logic      walk_match;
    logic      emit;
    rsp_beat_t emit_beat;

    utxo_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_bits)
    );

    assign rd_entry   = entry_t'(ram_rd_bits);
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign walk_done  = (idx_reg == count_reg) || (collected_reg >= SUM_W'(amt_reg));
    assign walk_match = !rd_entry.spent && (rd_entry.owner == key_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.action)
                        ACT_CREATE: state_next = ST_CREATE;
                        ACT_SPEND:  state_next = ST_WALK;
                        default:    state_next = ST_LOOKUP;
                    endcase
                end
            end
            ST_CREATE, ST_LOOKUP, ST_FINAL:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_FINAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control.
    always_comb
    begin
        req_stall      = (state_reg != ST_IDLE);
        ram_wr_en      = 1'b0;
        ram_wr_addr    = count_reg[IDX_W-1:0];
        ram_wr_data    = '{owner: key_reg, amount: amt_reg, spent: 1'b0};
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;
        emit           = 1'b0;
        emit_beat      = '{status: 1'b0, answer: 1'b0, result_id: '0, last: 1'b1};
        count_next     = count_reg;
        idx_next       = idx_reg;
        collected_next = collected_reg;
        short_next     = short_reg;
        change_next    = change_reg;
        act_next       = act_reg;
        key_next       = key_reg;
        amt_next       = amt_reg;
        id_next        = id_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    act_next       = req.action;
                    key_next       = req.owner_key;
                    amt_next       = req.amount;
                    id_next        = req.entry_id;
                    idx_next       = '0;
                    collected_next = '0;
                    ram_rd_en      = 1'b1;
                    if (req.action != ACT_SPEND)
                    begin
                        // Entry numbers start at 1; an unknown number reads
                        // an entry whose data is then ignored.
                        ram_rd_addr = IDX_W'(req.entry_id - ID_W'(1));
                    end
                end
            end
            ST_CREATE:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if ((count_reg != FULL_COUNT) && (amt_reg != '0))
                    begin
                        ram_wr_en           = 1'b1;
                        count_next          = count_reg + CNT_W'(1);
                        emit_beat.result_id = ID_W'(count_reg) + ID_W'(1);
                    end
                    else
                    begin
                        emit_beat.status = 1'b1;
                    end
                end
            end
            ST_LOOKUP:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if ((id_reg != '0) && (ID_W'(count_reg) >= id_reg))
                    begin
                        emit_beat.answer = (act_reg == ACT_CHECK) ? rd_entry.spent
                                                                  : !rd_entry.spent;
                    end
                    else
                    begin
                        emit_beat.answer = (act_reg == ACT_CHECK);
                    end
                end
            end
            ST_WALK:
            begin
                if (!walk_done && (!walk_match || slot_free))
                begin
                    // The next entry is read while a matching one is written back.
                    idx_next    = idx_reg + CNT_W'(1);
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = IDX_W'(idx_reg + CNT_W'(1));
                    if (walk_match)
                    begin
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = idx_reg[IDX_W-1:0];
                        ram_wr_data         = rd_entry;
                        ram_wr_data.spent   = 1'b1;
                        collected_next      = collected_reg + SUM_W'(rd_entry.amount);
                        emit                = 1'b1;
                        emit_beat.result_id = ID_W'(idx_reg) + ID_W'(1);
                        emit_beat.last      = 1'b0;
                    end
                end
            end
            ST_SETTLE:
            begin
                short_next  = (collected_reg < SUM_W'(amt_reg));
                change_next = AMT_W'(collected_reg - SUM_W'(amt_reg));
            end
            ST_FINAL:
            begin
                if (slot_free)
                begin
                    emit             = 1'b1;
                    emit_beat.status = short_reg;
                    ram_wr_data.amount = change_reg;
                    if (!short_reg && (change_reg != '0) && (count_reg != FULL_COUNT))
                    begin
                        ram_wr_en           = 1'b1;
                        count_next          = count_reg + CNT_W'(1);
                        emit_beat.result_id = ID_W'(count_reg) + ID_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_beat;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        collected_reg <= collected_next;
        short_reg     <= short_next;
        change_reg    <= change_next;
        act_reg       <= act_next;
        key_reg       <= key_next;
        amt_reg       <= amt_next;
        id_reg        <= id_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/utxo_checker.sv =====
// Port-level checks of the spend engine, bound to the top level.
module utxo_checker
    import utxo_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_beat_t req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_beat_t rsp
);

    // A held result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // The engine works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while previous item in progress");

    // A rejection or shortfall ends the item and names no entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |-> rsp.last && (rsp.result_id == '0))
        else $error("failing result beat malformed");

    // Every beat before the last one reports a spent entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> !rsp.status && !rsp.answer && (rsp.result_id != '0))
        else $error("intermediate result beat malformed");

    // A true lookup answer never comes with an entry number.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.answer |-> rsp.last && (rsp.result_id == '0))
        else $error("answer beat carries an entry number");

endmodule

bind utxo_table_spend_engine utxo_checker u_checker (.*);
